// ===== src/oops_pkg.sv =====
`default_nettype none

package oops_pkg;

  // pattern queue geometry
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // fixed field widths
  localparam int DUR_W    = 16;
  localparam int QUEUED_W = 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_VIBRATE = 2'd1,
    CMD_SET     = 2'd2
  } cmd_t;

  // one input item
  typedef struct packed {
    logic [1:0]       command;
    logic             level;
    logic [DUR_W-1:0] duration_ms;
  } cmd_item_t;

  // one result item
  typedef struct packed {
    logic                pin_level;
    logic                motor_on;
    logic [QUEUED_W-1:0] queued;
    logic                timer_armed;
    logic                dropped;
  } res_item_t;

  // one queued pattern entry
  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/oops_in_reg.sv =====
`default_nettype none

module oops_in_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire oops_pkg::cmd_item_t cmd_item,
  output logic                    held_valid,
  output oops_pkg::cmd_item_t     held_item,
  input  wire logic               take
);

  logic load;

  // load a new item when empty or when the held one moves on
  assign load      = !held_valid || take;
  assign cmd_stall = held_valid && !take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= cmd_valid;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (load && cmd_valid) begin
      held_item <= cmd_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/oops_core.sv =====
`default_nettype none

module oops_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                held_valid,
  input  wire oops_pkg::cmd_item_t held_item,
  output logic                     take,
  input  wire logic                pin_invert,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output oops_pkg::res_item_t      res_item
);

  // pattern queue storage
  oops_pkg::entry_t fifo [oops_pkg::FIFO_DEPTH];

  // sequencer state
  logic                               motor_state, motor_state_next;
  logic [oops_pkg::CNT_W-1:0]         fifo_count, fifo_count_next;
  logic [oops_pkg::PTR_W-1:0]         fifo_head, fifo_head_next;
  logic [oops_pkg::PTR_W-1:0]         fifo_tail, fifo_tail_next;
  logic [oops_pkg::DUR_W-1:0]         ticks_left, ticks_left_next;
  logic                               armed, armed_next;
  logic                               dropped;
  logic                               push;
  oops_pkg::entry_t                   head_entry;
  oops_pkg::entry_t                   push_entry;

  localparam logic [oops_pkg::PTR_W-1:0] LAST_SLOT = oops_pkg::PTR_W'(oops_pkg::FIFO_DEPTH - 1);
  localparam logic [oops_pkg::CNT_W-1:0] FULL_CNT  = oops_pkg::CNT_W'(oops_pkg::FIFO_DEPTH);

  // the held item moves on when the result register is free
  assign take = held_valid && (!res_valid || !res_stall);

  assign head_entry = fifo[fifo_head];
  assign push_entry = '{level: held_item.level, duration: held_item.duration_ms};

  // next state for the held item
  always_comb begin
    motor_state_next = motor_state;
    fifo_count_next  = fifo_count;
    fifo_head_next   = fifo_head;
    fifo_tail_next   = fifo_tail;
    ticks_left_next  = ticks_left;
    armed_next       = armed;
    dropped          = 1'b0;
    push             = 1'b0;
    case (held_item.command)
      oops_pkg::CMD_TICK: begin
        if (armed) begin
          if (ticks_left > oops_pkg::DUR_W'(1)) begin
            ticks_left_next = ticks_left - oops_pkg::DUR_W'(1);
          end else if (fifo_count == '0) begin
            // queue ran dry: motor off, countdown stops
            motor_state_next = 1'b0;
            armed_next       = 1'b0;
            ticks_left_next  = '0;
          end else begin
            // pop the head entry and hold its level
            fifo_head_next   = (fifo_head == LAST_SLOT) ? '0 : fifo_head + oops_pkg::PTR_W'(1);
            fifo_count_next  = fifo_count - oops_pkg::CNT_W'(1);
            motor_state_next = head_entry.level;
            ticks_left_next  = (head_entry.duration == '0) ? oops_pkg::DUR_W'(1)
                                                           : head_entry.duration;
          end
        end
      end
      oops_pkg::CMD_VIBRATE: begin
        if (!held_item.level && held_item.duration_ms == '0) begin
          // stop request clears everything
          fifo_count_next  = '0;
          fifo_head_next   = '0;
          fifo_tail_next   = '0;
          armed_next       = 1'b0;
          ticks_left_next  = '0;
          motor_state_next = 1'b0;
        end else if (fifo_count >= FULL_CNT) begin
          dropped = 1'b1;
        end else begin
          push            = 1'b1;
          fifo_tail_next  = (fifo_tail == LAST_SLOT) ? '0 : fifo_tail + oops_pkg::PTR_W'(1);
          fifo_count_next = fifo_count + oops_pkg::CNT_W'(1);
          // first entry re-arms the countdown for one tick
          if (fifo_count == '0) begin
            armed_next      = 1'b1;
            ticks_left_next = oops_pkg::DUR_W'(1);
          end
        end
      end
      oops_pkg::CMD_SET: begin
        motor_state_next = held_item.level;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_state <= 1'b0;
      fifo_count  <= '0;
      fifo_head   <= '0;
      fifo_tail   <= '0;
      ticks_left  <= '0;
      armed       <= 1'b0;
    end else if (take) begin
      motor_state <= motor_state_next;
      fifo_count  <= fifo_count_next;
      fifo_head   <= fifo_head_next;
      fifo_tail   <= fifo_tail_next;
      ticks_left  <= ticks_left_next;
      armed       <= armed_next;
    end
  end

  // queue write
  always_ff @(posedge clk) begin
    if (take && push) begin
      fifo[fifo_tail] <= push_entry;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_item.pin_level   <= motor_state_next ^ pin_invert;
      res_item.motor_on    <= motor_state_next;
      res_item.queued      <= oops_pkg::QUEUED_W'(fifo_count_next);
      res_item.timer_armed <= armed_next;
      res_item.dropped     <= dropped;
    end
  end

endmodule

`default_nettype wire

// ===== src/on_off_pattern_sequencer.sv =====
// Vibration motor pattern player.
// cmd channel (cmd_valid / cmd_stall / cmd_item), unless stalled, takes one
// item per cycle: a millisecond tick, a vibrate request (level and duration)
// or a direct level set. Vibrate requests wait in a 16-entry pattern queue;
// a request with level 0 and duration 0 stops playback and empties the queue.
// res channel (res_valid / res_stall / res_item) gives one result per item:
// pin level, motor state, queue fill, countdown armed and a dropped flag for
// a request that found the queue full.
// cfg channel (cfg_valid / cfg_ready / cfg_data) writes the pin inversion bit;
// it is always ready and is meant to be written while no item is in flight.
// The path from input acceptance to result runs through one input register,
// then the state update and result register. Throughput is one item per cycle
// while res_stall does not hold a result; the state update between those two
// registers is combinational.
// When res_stall holds a result, the next item waits in the input register
// and cmd_stall rises only once that register is occupied too.
// Synchronous reset turns the motor off, empties the queue, disarms the
// countdown and clears the pin inversion bit.
`default_nettype none

module on_off_pattern_sequencer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire oops_pkg::cmd_item_t cmd_item,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output oops_pkg::res_item_t      res_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  logic                held_valid;
  oops_pkg::cmd_item_t held_item;
  logic                take;
  logic                pin_invert;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_invert <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pin_invert <= cfg_data;
    end
  end

  // input register
  oops_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  // state update and result register
  oops_core u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .pin_invert (pin_invert),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  // queue fill never exceeds its depth
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.queued <= oops_pkg::QUEUED_W'(oops_pkg::FIFO_DEPTH))
    else $error("queue fill above depth");

  // a dropped request only happens with a full queue
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.dropped
      |-> res_item.queued == oops_pkg::QUEUED_W'(oops_pkg::FIFO_DEPTH))
    else $error("request dropped with room in queue");

  // a stopped countdown leaves nothing queued
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.timer_armed |-> res_item.queued == '0)
    else $error("entries queued while countdown is disarmed");

  // input stalls only behind a blocked result
  assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall)
    else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire
